FILE: design/prs_pkg.sv
// Shared constants and types for the partition row scatter block.
package prs_pkg;

    // Default sizes of the block.
    localparam int DEF_MAX_ROWS     = 64;
    localparam int DEF_MAX_CHANNELS = 16;

    // Fixed widths of the channel payloads.
    localparam int CID_W      = 9;
    localparam int IDX_W      = 6;
    localparam int CHAN_W     = 4;
    localparam int CHAN_MAX_W = 8;
    localparam int COUNT_W    = 7;
    localparam int CFG_W      = 5;

    // Reset value of the channel count register.
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One classified row, as handed from the front to the back.
    typedef struct packed {
        logic                  store;
        logic                  kept;
        logic                  last;
        logic                  eos;
        logic [IDX_W-1:0]      row_idx;
        logic [CHAN_MAX_W-1:0] ch;
    } prs_entry_t;

endpackage

FILE: design/prs_if.sv
// Channel interfaces for rows in, results out and configuration writes.
interface prs_row_if
    import prs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CID_W-1:0] channel_id;
    logic             last_row;
    logic             end_of_stream;

    modport source (output valid, output channel_id, output last_row,
                    output end_of_stream, input ready);
    modport sink   (input valid, input channel_id, input last_row,
                    input end_of_stream, output ready);
endinterface

interface prs_res_if
    import prs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               row_valid;
    logic [IDX_W-1:0]   row_index;
    logic [CHAN_W-1:0]  channel;
    logic               first_in_channel;
    logic [COUNT_W-1:0] channel_rows;
    logic [COUNT_W-1:0] dropped_rows;
    logic               stream_end;
    logic               last;

    modport source (output valid, output row_valid, output row_index, output channel,
                    output first_in_channel, output channel_rows, output dropped_rows,
                    output stream_end, output last, input ready);
    modport sink   (input valid, input row_valid, input row_index, input channel,
                    input first_in_channel, input channel_rows, input dropped_rows,
                    input stream_end, input last, output ready);
endinterface

interface prs_cfg_if
    import prs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/prs_front.sv
// Front end: accepts rows, checks the channel id and numbers the rows of a block.
module prs_front
    import prs_pkg::*;
#(
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic       clk,
    input  logic       rst_n,
    prs_row_if.sink    rows,
    prs_cfg_if.sink    cfg,
    input  logic       q_full,
    output logic       push,
    output prs_entry_t push_entry
);

    localparam int RI_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam logic [CNT_W-1:0] ROWS_C  = CNT_W'(MAX_ROWS);
    localparam logic [CID_W-1:0] CHANS_C = CID_W'(MAX_CHANNELS);

    logic [CFG_W-1:0] chan_count_reg;
    logic [CNT_W-1:0] row_cnt_reg;
    logic [CID_W-1:0] limit;
    logic             in_block;

    assign cfg.ready  = 1'b1;
    assign rows.ready = !q_full;
    assign push       = rows.valid && rows.ready;

    // The count register may exceed the channels that exist; clamp it.
    assign limit = (CID_W'(chan_count_reg) > CHANS_C) ? CHANS_C : CID_W'(chan_count_reg);

    // Rows beyond the block capacity are neither stored nor counted as dropped.
    assign in_block = row_cnt_reg < ROWS_C;

    always_comb
    begin
        push_entry.store   = in_block;
        push_entry.kept    = !rows.channel_id[CID_W-1] &&
                             ({1'b0, rows.channel_id[CID_W-2:0]} < limit);
        push_entry.last    = rows.last_row;
        push_entry.eos     = rows.end_of_stream;
        push_entry.row_idx = IDX_W'(row_cnt_reg[RI_W-1:0]);
        push_entry.ch      = rows.channel_id[CHAN_MAX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= CFG_RESET;
            row_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                chan_count_reg <= cfg.data;
            end
            if (push)
            begin
                if (rows.last_row)
                begin
                    row_cnt_reg <= '0;
                end
                else if (in_block)
                begin
                    row_cnt_reg <= row_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

endmodule

FILE: design/prs_queue.sv
// Short first-in first-out queue of classified rows between front and back.
module prs_queue
    import prs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  prs_entry_t push_entry,
    output logic       full,
    output logic       q_valid,
    output prs_entry_t q_entry,
    input  logic       pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FILL_W-1:0] DEPTH_C = FILL_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

    prs_entry_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    assign full    = fill_reg == DEPTH_C;
    assign q_valid = fill_reg != '0;
    assign q_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

endmodule

FILE: design/prs_back.sv
// Back end: histogram, prefix sum, scatter into channel order and result emission.
module prs_back
    import prs_pkg::*;
#(
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  prs_entry_t q_entry,
    output logic       pop,
    prs_res_if.source  results
);

    localparam int RI_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHC_W = $clog2(MAX_CHANNELS + 1);
    localparam int RS_W  = RI_W + CH_W;
    localparam int ORD_W = RI_W + CH_W + CNT_W;
    localparam logic [CNT_W-1:0] ROWS_C  = CNT_W'(MAX_ROWS);
    localparam logic [CHC_W-1:0] CHANS_C = CHC_W'(MAX_CHANNELS);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FLUSH,
        ST_PREFIX,
        ST_SCAT_A,
        ST_SCAT_B,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    state_t state_reg;

    // Stores.
    logic [RS_W-1:0]  rs_mem   [MAX_ROWS];
    logic [CNT_W-1:0] hist_mem [MAX_CHANNELS];
    logic [CNT_W-1:0] off_mem  [MAX_CHANNELS];
    logic [ORD_W-1:0] ord_mem  [MAX_ROWS];
    logic [MAX_CHANNELS-1:0] hist_vld_reg;

    logic [RS_W-1:0]  rs_rd_reg;
    logic [CNT_W-1:0] hist_rd_reg;
    logic             hist_rdv_reg;
    logic [CNT_W-1:0] off_rd_reg;
    logic [ORD_W-1:0] ord_rd_reg;

    // Block counters and load pipeline.
    logic [CNT_W-1:0] kept_cnt_reg;
    logic [CNT_W-1:0] drop_cnt_reg;
    logic             eos_reg;
    logic             p1_valid_reg;
    logic [CH_W-1:0]  p1_ch_reg;
    logic             fwd_reg;
    logic [CNT_W-1:0] fwd_val_reg;

    // Prefix, scatter and emission.
    logic [CHC_W-1:0] pf_c_reg;
    logic             pf_pend_reg;
    logic [CH_W-1:0]  pf_addr_reg;
    logic [CNT_W-1:0] acc_reg;
    logic [CNT_W-1:0] j_reg;
    logic [RI_W-1:0]  sc_idx_reg;
    logic [CH_W-1:0]  sc_ch_reg;
    logic [CNT_W-1:0] em_reg;
    logic [CH_W-1:0]  prev_ch_reg;

    // Result register.
    logic               out_valid_reg;
    logic               out_row_valid_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [CHAN_W-1:0]  out_ch_reg;
    logic               out_first_reg;
    logic [COUNT_W-1:0] out_rows_reg;
    logic [COUNT_W-1:0] out_drop_reg;
    logic               out_end_reg;
    logic               out_last_reg;

    logic [CH_W-1:0]  e_ch;
    logic [RI_W-1:0]  e_idx;
    logic             keep_row;
    logic [CNT_W-1:0] hist_cur;
    logic [CNT_W-1:0] hist_inc;
    logic [CNT_W-1:0] hist_cnt;
    logic             hist_we;
    logic [CH_W-1:0]  hist_addr;
    logic [CH_W-1:0]  hist_raddr;
    logic             pf_issue;
    logic             rs_re;
    logic [CNT_W-1:0] rs_next_j;
    logic [RI_W-1:0]  rs_raddr;
    logic [RI_W-1:0]  rs_idx;
    logic [CH_W-1:0]  rs_ch;
    logic [CH_W-1:0]  rs_ch_c;
    logic             off_we;
    logic [CH_W-1:0]  off_waddr;
    logic [CNT_W-1:0] off_wdata;
    logic             ord_we;
    logic [RI_W-1:0]  ord_idx;
    logic [CH_W-1:0]  ord_ch;
    logic [CNT_W-1:0] ord_cnt;
    logic [CHAN_MAX_W-1:0] ord_ch_wide;
    logic             empty;
    logic             res_last;
    logic             res_first;
    logic             out_free;
    logic             out_load;

    assign pop      = (state_reg == ST_LOAD) && q_valid;
    assign e_ch     = q_entry.ch[CH_W-1:0];
    assign e_idx    = q_entry.row_idx[RI_W-1:0];
    assign keep_row = pop && q_entry.store && q_entry.kept;

    // A row of the same channel straight behind takes the count just written.
    assign hist_cur = fwd_reg ? fwd_val_reg : (hist_rdv_reg ? hist_rd_reg : '0);
    assign hist_inc = hist_cur + CNT_W'(1);
    assign hist_cnt = hist_rdv_reg ? hist_rd_reg : '0;
    assign hist_we  = p1_valid_reg;

    assign pf_issue = pf_c_reg < CHANS_C;
    assign rs_idx   = rs_rd_reg[RS_W-1 -: RI_W];
    assign rs_ch    = rs_rd_reg[CH_W-1:0];
    assign rs_ch_c  = (CHC_W'(rs_ch) < CHANS_C) ? rs_ch : '0;

    always_comb
    begin
        unique case (state_reg)
            ST_LOAD:   hist_addr = e_ch;
            ST_PREFIX: hist_addr = pf_c_reg[CH_W-1:0];
            ST_SCAT_A: hist_addr = rs_ch;
            default:   hist_addr = '0;
        endcase
    end

    assign hist_raddr = (CHC_W'(hist_addr) < CHANS_C) ? hist_addr : '0;

    assign rs_re     = (state_reg == ST_PREFIX) || (state_reg == ST_SCAT_A);
    assign rs_next_j = j_reg + CNT_W'(1);
    assign rs_raddr  = ((state_reg == ST_SCAT_A) && (rs_next_j < ROWS_C)) ?
                       rs_next_j[RI_W-1:0] : '0;

    assign ord_we    = state_reg == ST_SCAT_B;
    assign off_we    = ((state_reg == ST_PREFIX) && pf_pend_reg) || ord_we;
    assign off_waddr = ord_we ? sc_ch_reg : pf_addr_reg;
    assign off_wdata = ord_we ? off_rd_reg + CNT_W'(1) : acc_reg;

    assign ord_idx     = ord_rd_reg[ORD_W-1 -: RI_W];
    assign ord_ch      = ord_rd_reg[CNT_W +: CH_W];
    assign ord_cnt     = ord_rd_reg[CNT_W-1:0];
    assign ord_ch_wide = CHAN_MAX_W'(ord_ch);

    assign empty     = kept_cnt_reg == '0;
    assign res_last  = empty || (em_reg == kept_cnt_reg - CNT_W'(1));
    assign res_first = !empty && ((em_reg == '0) || (ord_ch != prev_ch_reg));
    assign out_free  = !out_valid_reg || results.ready;
    assign out_load  = (state_reg == ST_EMIT_OUT) && out_free;

    assign results.valid            = out_valid_reg;
    assign results.row_valid        = out_row_valid_reg;
    assign results.row_index        = out_idx_reg;
    assign results.channel          = out_ch_reg;
    assign results.first_in_channel = out_first_reg;
    assign results.channel_rows     = out_rows_reg;
    assign results.dropped_rows     = out_drop_reg;
    assign results.stream_end       = out_end_reg;
    assign results.last             = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (keep_row)
        begin
            rs_mem[kept_cnt_reg[RI_W-1:0]] <= {e_idx, e_ch};
        end
        if (rs_re)
        begin
            rs_rd_reg <= rs_mem[rs_raddr];
        end
        if (hist_we)
        begin
            hist_mem[p1_ch_reg] <= hist_inc;
        end
        hist_rd_reg <= hist_mem[hist_raddr];
        if (off_we)
        begin
            off_mem[off_waddr] <= off_wdata;
        end
        off_rd_reg <= off_mem[rs_ch_c];
        if (ord_we)
        begin
            ord_mem[off_rd_reg[RI_W-1:0]] <= {sc_idx_reg, sc_ch_reg, hist_cnt};
        end
        ord_rd_reg <= ord_mem[em_reg[RI_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_LOAD;
            hist_vld_reg      <= '0;
            hist_rdv_reg      <= 1'b0;
            kept_cnt_reg      <= '0;
            drop_cnt_reg      <= '0;
            eos_reg           <= 1'b0;
            p1_valid_reg      <= 1'b0;
            p1_ch_reg         <= '0;
            fwd_reg           <= 1'b0;
            fwd_val_reg       <= '0;
            pf_c_reg          <= '0;
            pf_pend_reg       <= 1'b0;
            pf_addr_reg       <= '0;
            acc_reg           <= '0;
            j_reg             <= '0;
            sc_idx_reg        <= '0;
            sc_ch_reg         <= '0;
            em_reg            <= '0;
            prev_ch_reg       <= '0;
            out_valid_reg     <= 1'b0;
            out_row_valid_reg <= 1'b0;
            out_idx_reg       <= '0;
            out_ch_reg        <= '0;
            out_first_reg     <= 1'b0;
            out_rows_reg      <= '0;
            out_drop_reg      <= '0;
            out_end_reg       <= 1'b0;
            out_last_reg      <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= keep_row;
            p1_ch_reg    <= e_ch;
            fwd_reg      <= keep_row && p1_valid_reg && (e_ch == p1_ch_reg);
            fwd_val_reg  <= hist_inc;
            hist_rdv_reg <= hist_vld_reg[hist_raddr];
            if (hist_we)
            begin
                hist_vld_reg[p1_ch_reg] <= 1'b1;
            end
            if (results.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (pop)
                    begin
                        if (keep_row)
                        begin
                            kept_cnt_reg <= kept_cnt_reg + CNT_W'(1);
                        end
                        if (q_entry.store && !q_entry.kept)
                        begin
                            drop_cnt_reg <= drop_cnt_reg + CNT_W'(1);
                        end
                        if (q_entry.last)
                        begin
                            eos_reg   <= q_entry.eos;
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    pf_c_reg    <= '0;
                    pf_pend_reg <= 1'b0;
                    acc_reg     <= '0;
                    state_reg   <= ST_PREFIX;
                end
                ST_PREFIX:
                begin
                    pf_c_reg    <= pf_c_reg + CHC_W'(pf_issue);
                    pf_pend_reg <= pf_issue;
                    pf_addr_reg <= pf_c_reg[CH_W-1:0];
                    if (pf_pend_reg)
                    begin
                        acc_reg <= acc_reg + hist_cnt;
                    end
                    if (!pf_issue && !pf_pend_reg)
                    begin
                        j_reg     <= '0;
                        state_reg <= ST_SCAT_A;
                    end
                end
                ST_SCAT_A:
                begin
                    if (j_reg == kept_cnt_reg)
                    begin
                        em_reg    <= '0;
                        state_reg <= empty ? ST_EMIT_OUT : ST_EMIT_RD;
                    end
                    else
                    begin
                        sc_idx_reg <= rs_idx;
                        sc_ch_reg  <= rs_ch;
                        state_reg  <= ST_SCAT_B;
                    end
                end
                ST_SCAT_B:
                begin
                    j_reg     <= rs_next_j;
                    state_reg <= ST_SCAT_A;
                end
                ST_EMIT_RD:
                begin
                    state_reg <= ST_EMIT_OUT;
                end
                ST_EMIT_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_row_valid_reg <= !empty;
                        out_idx_reg       <= empty ? '0 : IDX_W'(ord_idx);
                        out_ch_reg        <= empty ? '0 : ord_ch_wide[CHAN_W-1:0];
                        out_first_reg     <= res_first;
                        out_rows_reg      <= empty ? '0 : COUNT_W'(ord_cnt);
                        out_drop_reg      <= COUNT_W'(drop_cnt_reg);
                        out_end_reg       <= res_last && eos_reg;
                        out_last_reg      <= res_last;
                        prev_ch_reg       <= ord_ch;
                        if (res_last)
                        begin
                            kept_cnt_reg <= '0;
                            drop_cnt_reg <= '0;
                            hist_vld_reg <= '0;
                            em_reg       <= '0;
                            state_reg    <= ST_LOAD;
                        end
                        else
                        begin
                            em_reg    <= em_reg + CNT_W'(1);
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // Every scattered row lands inside the kept part of the ordered store.
    a_scatter_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ord_we |-> (off_rd_reg < kept_cnt_reg))
        else $error("scatter position beyond kept row count");

    // The row store is never written beyond its depth.
    a_store_depth: assert property (@(posedge clk) disable iff (!rst_n)
        keep_row |-> (kept_cnt_reg < ROWS_C))
        else $error("row store overflow");

    // Count forwarding only happens behind a pending histogram write.
    a_fwd_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> p1_valid_reg)
        else $error("histogram forward without pending write");

    // The final result of a block leaves the back end empty and loading.
    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_last) |=> ((state_reg == ST_LOAD) && (kept_cnt_reg == '0)
                                   && (hist_vld_reg == '0)))
        else $error("block state not cleared after final result");

    // The load pipeline is empty whenever the channel walk runs.
    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREFIX) |-> !p1_valid_reg)
        else $error("histogram update still pending during prefix sum");

endmodule

FILE: design/partition_row_scatter.sv
// Top level of the partition row scatter block.
//
//  Channel   Modport               Transaction carries
//  -------   -------------------   ----------------------------------------------------
//  rows      prs_row_if.sink       channel_id, last_row, end_of_stream
//  results   prs_res_if.source     row_valid, row_index, channel, first_in_channel,
//                                  channel_rows, dropped_rows, stream_end, last
//  cfg       prs_cfg_if.sink       data: number of destination channels in use
//
// Rows are taken one per cycle into a short queue while it is not full, and the back
// end loads them into the histogram at one per cycle while it is in its load state.
// After the last row of a block, the back end walks the channels for the prefix sum,
// scatters each kept row with a registered read and write back of the offset store,
// and emits each result after a registered read of the ordered store; it takes no
// rows of the next block until it has loaded the final result of a block.
// Reset is asynchronous and active low; no clearing pass is needed, as histogram
// entries carry valid bits that reset and end of block clear at once.
// A stall on results holds the back end, while the front keeps taking rows until the
// queue fills.
module partition_row_scatter
    import prs_pkg::*;
#(
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic      clk,
    input  logic      rst_n,
    prs_row_if.sink   rows,
    prs_res_if.source results,
    prs_cfg_if.sink   cfg
);

    // Classified rows pass from the front to the back through the queue.
    logic       push;
    prs_entry_t push_entry;
    logic       q_full;
    logic       q_valid;
    prs_entry_t q_entry;
    logic       pop;

    // The front holds the channel count, numbers the rows of the block and
    // decides for each row whether it is kept or dropped.
    prs_front #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rows       (rows),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // The queue lets the next block's rows arrive while results still drain.
    prs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop)
    );

    // The back builds the histogram, the offsets and the channel-ordered rows,
    // and then emits the results through its output register.
    prs_back #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (pop),
        .results (results)
    );

endmodule
